// ----- rtl/assert_macros.svh -----
// Assertion macros used by bridge_precharge_startup_sequencer.
// Expects clk and arst_n in the scope of each use; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define ASSERT_IMPL(lbl, cond, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/bpss_pkg.sv -----
// Types and constants of the bridge precharge start-up sequencer.
// Used by bpss_core and bridge_precharge_startup_sequencer.
package bpss_pkg;

	localparam int CELL_COUNT = 3;
	localparam int VOLT_W = 16;
	localparam int SUM_W = VOLT_W + $clog2(CELL_COUNT + 1);
	localparam int GAIN_FRAC = 14;
	localparam int PROD_W = 2 * VOLT_W;
	localparam int CMP_W = (SUM_W + GAIN_FRAC > PROD_W) ? SUM_W + GAIN_FRAC : PROD_W;
	localparam int THR_W = 10;
	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_QUAL_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRECHG_TMO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_GAIN = 2'd3;

	localparam logic [THR_W-1:0] QUAL_THR_RST = 10'd500;
	localparam logic [CNT_W-1:0] PRECHG_TMO_RST = 16'd5000;
	localparam logic [CNT_W-1:0] HOLD_TICKS_RST = 16'd100;
	localparam logic [VOLT_W-1:0] PEAK_GAIN_RST = 16'd20854;

	typedef enum logic [2:0] {
		PH_INIT  = 3'd0,
		PH_IDLE  = 3'd1,
		PH_SOFT  = 3'd2,
		PH_MAIN  = 3'd3,
		PH_RUN   = 3'd4,
		PH_FAULT = 3'd5
	} phase_t;

	typedef struct packed {
		logic [THR_W-1:0] qual_thr;
		logic [CNT_W-1:0] prechg_tmo;
		logic [CNT_W-1:0] hold_ticks;
		logic [VOLT_W-1:0] peak_gain;
	} cfg_t;

	typedef struct packed {
		logic platform_ready;
		logic sample_healthy;
		logic run_request;
		logic main_relay_closed;
		logic clear_request;
		logic bus_ok;
	} step_t;

	typedef struct packed {
		phase_t phase;
		logic run_permit;
		logic precharge_relay_on;
		logic main_relay_request;
		logic pwm_block;
		logic fault_latched;
	} res_t;

endpackage

// ----- rtl/bpss_core.sv -----
// Phase state machine with its counters and relay commands.
// Depends on bpss_pkg; advanced once per request by step_en.
module bpss_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  bpss_pkg::step_t step,
	input  bpss_pkg::cfg_t  cfg,
	output bpss_pkg::res_t  res
);

	bpss_pkg::phase_t phase_q, phase_n;
	logic [bpss_pkg::CNT_W-1:0] elapsed_q, elapsed_n;
	logic [bpss_pkg::THR_W-1:0] qualify_q, qualify_n;
	logic [bpss_pkg::CNT_W-1:0] hold_q, hold_n;
	logic precharge_q, precharge_n;
	logic main_req_q, main_req_n;
	logic run_permit_q, run_permit_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bpss_pkg::PH_INIT;
			elapsed_q <= '0;
			qualify_q <= '0;
			hold_q <= '0;
			precharge_q <= 1'b0;
			main_req_q <= 1'b0;
			run_permit_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			elapsed_q <= elapsed_n;
			qualify_q <= qualify_n;
			hold_q <= hold_n;
			precharge_q <= precharge_n;
			main_req_q <= main_req_n;
			run_permit_q <= run_permit_n;
		end
	end

	always_comb begin
		logic go;
		bpss_pkg::phase_t go_phase;
		go = 1'b0;
		go_phase = bpss_pkg::PH_INIT;
		phase_n = phase_q;
		elapsed_n = elapsed_q;
		qualify_n = qualify_q;
		hold_n = hold_q;
		precharge_n = precharge_q;
		main_req_n = main_req_q;
		run_permit_n = run_permit_q;

		case (phase_q)
			bpss_pkg::PH_IDLE: begin
				if (step.run_request) begin
					go = 1'b1;
					go_phase = bpss_pkg::PH_SOFT;
				end
			end
			bpss_pkg::PH_SOFT: begin
				if (!step.run_request) begin
					go = 1'b1;
					go_phase = bpss_pkg::PH_IDLE;
				end else begin
					if (elapsed_q != {bpss_pkg::CNT_W{1'b1}})
						elapsed_n = elapsed_q + 1'b1;
					if (step.bus_ok) begin
						if (qualify_q < cfg.qual_thr)
							qualify_n = qualify_q + 1'b1;
					end else if (qualify_q != '0) begin
						qualify_n = qualify_q - 1'b1;
					end
					if (qualify_n >= cfg.qual_thr) begin
						go = 1'b1;
						go_phase = bpss_pkg::PH_MAIN;
					end else if (elapsed_n >= cfg.prechg_tmo) begin
						go = 1'b1;
						go_phase = bpss_pkg::PH_FAULT;
					end
				end
			end
			bpss_pkg::PH_MAIN: begin
				if (!step.run_request) begin
					go = 1'b1;
					go_phase = bpss_pkg::PH_IDLE;
				end else if (step.main_relay_closed) begin
					if (hold_q == '0)
						precharge_n = 1'b0;
					if (hold_q < cfg.hold_ticks)
						hold_n = hold_q + 1'b1;
					if (hold_n >= cfg.hold_ticks) begin
						go = 1'b1;
						go_phase = bpss_pkg::PH_RUN;
					end
				end else begin
					hold_n = '0;
				end
			end
			bpss_pkg::PH_RUN: begin
				if (!step.run_request) begin
					go = 1'b1;
					go_phase = bpss_pkg::PH_IDLE;
				end else begin
					run_permit_n = 1'b1;
				end
			end
			bpss_pkg::PH_FAULT: begin
				if (step.clear_request && !step.run_request) begin
					go = 1'b1;
					go_phase = bpss_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_n = bpss_pkg::PH_INIT;
				if (step.platform_ready && step.sample_healthy) begin
					go = 1'b1;
					go_phase = bpss_pkg::PH_IDLE;
				end
			end
		endcase

		if (go) begin
			phase_n = go_phase;
			run_permit_n = 1'b0;
			case (go_phase)
				bpss_pkg::PH_IDLE, bpss_pkg::PH_FAULT: begin
					precharge_n = 1'b0;
					main_req_n = 1'b0;
				end
				bpss_pkg::PH_SOFT: begin
					elapsed_n = '0;
					qualify_n = '0;
					main_req_n = 1'b0;
					precharge_n = 1'b1;
				end
				bpss_pkg::PH_MAIN: begin
					hold_n = '0;
					main_req_n = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign res.phase = phase_n;
	assign res.run_permit = run_permit_n;
	assign res.precharge_relay_on = precharge_n;
	assign res.main_relay_request = main_req_n;
	assign res.pwm_block = (phase_n != bpss_pkg::PH_RUN);
	assign res.fault_latched = (phase_n == bpss_pkg::PH_FAULT);

endmodule

// ----- rtl/bridge_precharge_startup_sequencer.sv -----
// Start-up sequencer for a cascaded H-bridge: precharge, main relay and run permission.
// Depends on bpss_pkg, bpss_core and assert_macros.svh.
//
// One request per 1 ms tick on the slave stream gives one result on the master stream,
// the phase and relay commands after that tick. Requests are taken every cycle while the
// result side keeps up. A taken request lands in the input register, then the bus compare
// and the state machine update run in one pass and the result register loads. A stalled
// result holds the input register; the input stalls only while both are full.
// Configuration registers may be written only while no request is in flight.
`include "assert_macros.svh"
module bridge_precharge_startup_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bpss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// platform_ready, sample_healthy, run_request, bus_volt_cell_a, bus_volt_cell_b,
	// bus_volt_cell_c, grid_rms_volt, main_relay_closed, clear_request, zero fill
	input  logic [bpss_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// phase, run_permit, precharge_relay_on, main_relay_request, pwm_block, fault_latched
	output logic [bpss_pkg::OUT_DATA_W-1:0]     m_tdata
);

	bpss_pkg::cfg_t cfg_q;

	logic s1_valid;
	logic [bpss_pkg::IN_DATA_W-1:0] data_s1;
	logic out_valid_q;
	bpss_pkg::res_t res_q;

	logic out_adv, s1_adv, step_en;
	logic [bpss_pkg::VOLT_W-1:0] cell_v [bpss_pkg::CELL_COUNT];
	logic [bpss_pkg::SUM_W-1:0] sum_s1;
	logic [bpss_pkg::VOLT_W-1:0] rms_s1;
	logic [bpss_pkg::PROD_W-1:0] prod_s1;
	bpss_pkg::step_t step;
	bpss_pkg::res_t res;
	logic chk_run, chk_fault, chk_soft;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.qual_thr <= bpss_pkg::QUAL_THR_RST;
			cfg_q.prechg_tmo <= bpss_pkg::PRECHG_TMO_RST;
			cfg_q.hold_ticks <= bpss_pkg::HOLD_TICKS_RST;
			cfg_q.peak_gain <= bpss_pkg::PEAK_GAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bpss_pkg::REG_QUAL_THR: cfg_q.qual_thr <= cfg_data[bpss_pkg::THR_W-1:0];
				bpss_pkg::REG_PRECHG_TMO: cfg_q.prechg_tmo <= cfg_data;
				bpss_pkg::REG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_data;
				bpss_pkg::REG_PEAK_GAIN: cfg_q.peak_gain <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_adv = !out_valid_q || m_tready;
	assign s1_adv = !s1_valid || out_adv;
	assign s_tready = s1_adv;
	assign step_en = s1_valid && out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv)
				s1_valid <= s_tvalid;
			if (out_adv)
				out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s_tvalid)
			data_s1 <= s_tdata;
	end

	assign cell_v[0] = data_s1[18:3];
	if (bpss_pkg::CELL_COUNT > 1) begin : g_cell_b
		assign cell_v[1] = data_s1[34:19];
	end
	if (bpss_pkg::CELL_COUNT > 2) begin : g_cell_c
		assign cell_v[2] = data_s1[50:35];
	end
	assign rms_s1 = data_s1[66:51];

	always_comb begin
		sum_s1 = '0;
		for (int i = 0; i < bpss_pkg::CELL_COUNT; i++)
			sum_s1 = sum_s1 + bpss_pkg::SUM_W'(cell_v[i]);
	end

	assign prod_s1 = bpss_pkg::PROD_W'(cfg_q.peak_gain) * bpss_pkg::PROD_W'(rms_s1);

	always_comb begin
		step.platform_ready = data_s1[0];
		step.sample_healthy = data_s1[1];
		step.run_request = data_s1[2];
		step.main_relay_closed = data_s1[67];
		step.clear_request = data_s1[68];
		step.bus_ok = bpss_pkg::CMP_W'({sum_s1, bpss_pkg::GAIN_FRAC'(0)})
			> bpss_pkg::CMP_W'(prod_s1);
	end

	bpss_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.step    (step),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk) begin
		if (step_en)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {res_q.fault_latched, res_q.pwm_block, res_q.main_relay_request,
		res_q.precharge_relay_on, res_q.run_permit, 3'(res_q.phase)};

	assign chk_run = m_tvalid && res_q.run_permit;
	assign chk_fault = m_tvalid && res_q.fault_latched
		&& (res_q.precharge_relay_on || res_q.main_relay_request);
	assign chk_soft = m_tvalid && (res_q.phase == bpss_pkg::PH_SOFT)
		&& !(res_q.precharge_relay_on && !res_q.main_relay_request);

	`ASSERT_IMPL(a_run_only_in_run, chk_run, res_q.phase == bpss_pkg::PH_RUN, "run outside run")
	`ASSERT_NEVER(a_fault_relays_open, chk_fault, "relay command active in fault")
	`ASSERT_IMPL(a_ready_when_empty, !out_valid_q, s_tready, "input stalled while empty")
	`ASSERT_NEVER(a_soft_precharge, chk_soft, "soft start without precharge relay")

endmodule
